[hdl/pit_pkg.sv]
package pit_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
   localparam int DOT_WIDTH   = PROD_WIDTH + 2;
   localparam int LO_WIDTH    = DOT_WIDTH / 2;
   localparam int HI_WIDTH    = DOT_WIDTH - LO_WIDTH;
   localparam int PART_WIDTH  = 2 * (LO_WIDTH + 1);
   localparam int WIDE_WIDTH  = 2 * DOT_WIDTH;
   localparam int NUM_WIDTH   = WIDE_WIDTH + 1;
   localparam int SUM_WIDTH   = WIDE_WIDTH + 2;

   localparam int DOT_STAGES  = 3;
   localparam int MUL_STAGES  = 2;
   localparam int DEC_STAGES  = 2;
   localparam int NUM_STAGES  = DOT_STAGES + MUL_STAGES + DEC_STAGES;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_WIDTH-1:0]  diff_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;
   typedef logic signed [DOT_WIDTH-1:0]   dot_type;
   typedef logic signed [WIDE_WIDTH-1:0]  wide_type;

   typedef struct packed {
      coord_type v0_x;
      coord_type v0_y;
      coord_type v0_z;
      coord_type v1_x;
      coord_type v1_y;
      coord_type v1_z;
      coord_type v2_x;
      coord_type v2_y;
      coord_type v2_z;
      coord_type point_x;
      coord_type point_y;
      coord_type point_z;
   } req_type;

   typedef struct packed {
      logic inside_res;
      logic degenerate;
   } rsp_type;

   typedef struct packed {
      dot_type uu;
      dot_type uv;
      dot_type vv;
      dot_type wu;
      dot_type wv;
   } dots_type;

   typedef struct packed {
      wide_type uvuv;
      wide_type uuvv;
      wide_type uvwv;
      wide_type vvwu;
      wide_type uvwu;
      wide_type uuwv;
   } prods_type;

endpackage

[hdl/pit_dot_stage.sv]
module pit_dot_stage (
   input  logic                                  clock,
   input  logic [pit_pkg::DOT_STAGES-1:0]        stage_en,
   input  pit_pkg::req_type                      req_data,
   output pit_pkg::dots_type                     dots
);
   import pit_pkg::*;

   diff_type  u_ff [3];
   diff_type  v_ff [3];
   diff_type  w_ff [3];
   diff_type  u_in [3];
   diff_type  v_in [3];
   diff_type  w_in [3];
   prod_type  uu_ff [3];
   prod_type  uv_ff [3];
   prod_type  vv_ff [3];
   prod_type  wu_ff [3];
   prod_type  wv_ff [3];
   prod_type  uu_in [3];
   prod_type  uv_in [3];
   prod_type  vv_in [3];
   prod_type  wu_in [3];
   prod_type  wv_in [3];
   dots_type  dots_ff;
   dots_type  dots_in;
   coord_type c0 [3];
   coord_type c1 [3];
   coord_type c2 [3];
   coord_type cp [3];

   assign c0[0] = req_data.v0_x;
   assign c0[1] = req_data.v0_y;
   assign c0[2] = req_data.v0_z;
   assign c1[0] = req_data.v1_x;
   assign c1[1] = req_data.v1_y;
   assign c1[2] = req_data.v1_z;
   assign c2[0] = req_data.v2_x;
   assign c2[1] = req_data.v2_y;
   assign c2[2] = req_data.v2_z;
   assign cp[0] = req_data.point_x;
   assign cp[1] = req_data.point_y;
   assign cp[2] = req_data.point_z;

   // edge vectors and point offset
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         u_in[k] = DIFF_WIDTH'(c1[k]) - DIFF_WIDTH'(c0[k]);
         v_in[k] = DIFF_WIDTH'(c2[k]) - DIFF_WIDTH'(c0[k]);
         w_in[k] = DIFF_WIDTH'(cp[k]) - DIFF_WIDTH'(c0[k]);
      end
   end

   // per-axis products
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         uu_in[k] = PROD_WIDTH'(u_ff[k]) * PROD_WIDTH'(u_ff[k]);
         uv_in[k] = PROD_WIDTH'(u_ff[k]) * PROD_WIDTH'(v_ff[k]);
         vv_in[k] = PROD_WIDTH'(v_ff[k]) * PROD_WIDTH'(v_ff[k]);
         wu_in[k] = PROD_WIDTH'(w_ff[k]) * PROD_WIDTH'(u_ff[k]);
         wv_in[k] = PROD_WIDTH'(w_ff[k]) * PROD_WIDTH'(v_ff[k]);
      end
   end

   // dot product sums
   always_comb begin
      dots_in.uu = DOT_WIDTH'(uu_ff[0]) + DOT_WIDTH'(uu_ff[1]) + DOT_WIDTH'(uu_ff[2]);
      dots_in.uv = DOT_WIDTH'(uv_ff[0]) + DOT_WIDTH'(uv_ff[1]) + DOT_WIDTH'(uv_ff[2]);
      dots_in.vv = DOT_WIDTH'(vv_ff[0]) + DOT_WIDTH'(vv_ff[1]) + DOT_WIDTH'(vv_ff[2]);
      dots_in.wu = DOT_WIDTH'(wu_ff[0]) + DOT_WIDTH'(wu_ff[1]) + DOT_WIDTH'(wu_ff[2]);
      dots_in.wv = DOT_WIDTH'(wv_ff[0]) + DOT_WIDTH'(wv_ff[1]) + DOT_WIDTH'(wv_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         u_ff <= u_in;
         v_ff <= v_in;
         w_ff <= w_in;
      end
      if (stage_en[1]) begin
         uu_ff <= uu_in;
         uv_ff <= uv_in;
         vv_ff <= vv_in;
         wu_ff <= wu_in;
         wv_ff <= wv_in;
      end
      if (stage_en[2]) begin
         dots_ff <= dots_in;
      end
   end

   assign dots = dots_ff;

endmodule

[hdl/pit_wide_mul.sv]
module pit_wide_mul (
   input  logic                                  clock,
   input  logic [pit_pkg::MUL_STAGES-1:0]        stage_en,
   input  pit_pkg::dot_type                      a,
   input  pit_pkg::dot_type                      b,
   output pit_pkg::wide_type                     p
);
   import pit_pkg::*;

   logic signed [LO_WIDTH:0]      a_lo;
   logic signed [LO_WIDTH:0]      b_lo;
   logic signed [HI_WIDTH-1:0]    a_hi;
   logic signed [HI_WIDTH-1:0]    b_hi;
   logic signed [PART_WIDTH-1:0]  ll_ff;
   logic signed [PART_WIDTH-1:0]  lh_ff;
   logic signed [PART_WIDTH-1:0]  hl_ff;
   logic signed [PART_WIDTH-1:0]  hh_ff;
   logic signed [PART_WIDTH-1:0]  ll_in;
   logic signed [PART_WIDTH-1:0]  lh_in;
   logic signed [PART_WIDTH-1:0]  hl_in;
   logic signed [PART_WIDTH-1:0]  hh_in;
   wide_type                      p_ff;
   wide_type                      p_in;
   wide_type                      mid;

   // low halves unsigned, high halves signed
   assign a_lo = {1'b0, a[LO_WIDTH-1:0]};
   assign b_lo = {1'b0, b[LO_WIDTH-1:0]};
   assign a_hi = a[DOT_WIDTH-1:LO_WIDTH];
   assign b_hi = b[DOT_WIDTH-1:LO_WIDTH];

   assign ll_in = PART_WIDTH'(a_lo) * PART_WIDTH'(b_lo);
   assign lh_in = PART_WIDTH'(a_lo) * PART_WIDTH'(b_hi);
   assign hl_in = PART_WIDTH'(a_hi) * PART_WIDTH'(b_lo);
   assign hh_in = PART_WIDTH'(a_hi) * PART_WIDTH'(b_hi);

   assign mid  = WIDE_WIDTH'(lh_ff) + WIDE_WIDTH'(hl_ff);
   assign p_in = (WIDE_WIDTH'(hh_ff) <<< (2 * LO_WIDTH)) + (mid <<< LO_WIDTH)
               + WIDE_WIDTH'(ll_ff);

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         ll_ff <= ll_in;
         lh_ff <= lh_in;
         hl_ff <= hl_in;
         hh_ff <= hh_in;
      end
      if (stage_en[1]) begin
         p_ff <= p_in;
      end
   end

   assign p = p_ff;

endmodule

[hdl/pit_decide.sv]
module pit_decide (
   input  logic                                  clock,
   input  logic [pit_pkg::DEC_STAGES-1:0]        stage_en,
   input  pit_pkg::prods_type                    prods,
   output pit_pkg::rsp_type                      result
);
   import pit_pkg::*;

   logic signed [NUM_WIDTH-1:0] d_ff;
   logic signed [NUM_WIDTH-1:0] sn_ff;
   logic signed [NUM_WIDTH-1:0] tn_ff;
   logic signed [SUM_WIDTH-1:0] st_ff;
   logic signed [NUM_WIDTH-1:0] d_in;
   logic signed [NUM_WIDTH-1:0] sn_in;
   logic signed [NUM_WIDTH-1:0] tn_in;
   logic signed [SUM_WIDTH-1:0] st_in;
   logic                        degen;
   rsp_type                     result_ff;
   rsp_type                     result_in;

   assign d_in  = NUM_WIDTH'(prods.uvuv) - NUM_WIDTH'(prods.uuvv);
   assign sn_in = NUM_WIDTH'(prods.uvwv) - NUM_WIDTH'(prods.vvwu);
   assign tn_in = NUM_WIDTH'(prods.uvwu) - NUM_WIDTH'(prods.uuwv);
   assign st_in = SUM_WIDTH'(prods.uvwv) - SUM_WIDTH'(prods.vvwu)
                + SUM_WIDTH'(prods.uvwu) - SUM_WIDTH'(prods.uuwv);

   // d is never positive, so the tests work on numerators against d
   assign degen = (d_ff == '0);
   assign result_in.degenerate = degen;
   assign result_in.inside_res = !degen && (sn_ff <= 0) && (sn_ff >= d_ff)
                               && (tn_ff <= 0) && (st_ff >= SUM_WIDTH'(d_ff));

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         d_ff  <= d_in;
         sn_ff <= sn_in;
         tn_ff <= tn_in;
         st_ff <= st_in;
      end
      if (stage_en[1]) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

[hdl/point_in_triangle_test_unit.sv]
// point-in-triangle test unit
//
// req channel: one item carries three triangle vertices and a query point,
// each a signed 3D coordinate on one common fixed-point scale. rsp channel:
// one item per request, in order, with inside_res (point projected onto the
// triangle plane lies within or on the triangle) and degenerate (zero-area
// triangle, then inside_res is 0).
//
// each item passes through 7 register stages: edge vectors, per-axis products,
// dot product sums, split wide multiply partial products and their sum for
// the six dot-product products, numerators, then the compares. throughput
// is one item per clock while rsp_stall is low; every stage holds its own
// valid bit.
//
// reset clears all valid bits; no item is in flight afterwards. when the
// receiver stalls, the last stage holds its item and earlier stages keep
// filling empty slots, so req_stall rises only once the whole pipe is full.
module point_in_triangle_test_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pit_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pit_pkg::rsp_type  rsp_data
);
   import pit_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES:0]   ready;
   logic [NUM_STAGES-1:0] stage_en;
   dots_type              dots;
   prods_type             prods;

   always_comb begin
      ready[NUM_STAGES] = !rsp_stall;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
   end

   assign stage_en = ready[NUM_STAGES-1:0];
   assign valid_in = {valid_ff[NUM_STAGES-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   pit_dot_stage u_dot (
      .clock    (clock),
      .stage_en (stage_en[DOT_STAGES-1:0]),
      .req_data (req_data),
      .dots     (dots)
   );

   pit_wide_mul u_mul_uvuv (
      .clock    (clock),
      .stage_en (stage_en[DOT_STAGES+MUL_STAGES-1:DOT_STAGES]),
      .a        (dots.uv),
      .b        (dots.uv),
      .p        (prods.uvuv)
   );

   pit_wide_mul u_mul_uuvv (
      .clock    (clock),
      .stage_en (stage_en[DOT_STAGES+MUL_STAGES-1:DOT_STAGES]),
      .a        (dots.uu),
      .b        (dots.vv),
      .p        (prods.uuvv)
   );

   pit_wide_mul u_mul_uvwv (
      .clock    (clock),
      .stage_en (stage_en[DOT_STAGES+MUL_STAGES-1:DOT_STAGES]),
      .a        (dots.uv),
      .b        (dots.wv),
      .p        (prods.uvwv)
   );

   pit_wide_mul u_mul_vvwu (
      .clock    (clock),
      .stage_en (stage_en[DOT_STAGES+MUL_STAGES-1:DOT_STAGES]),
      .a        (dots.vv),
      .b        (dots.wu),
      .p        (prods.vvwu)
   );

   pit_wide_mul u_mul_uvwu (
      .clock    (clock),
      .stage_en (stage_en[DOT_STAGES+MUL_STAGES-1:DOT_STAGES]),
      .a        (dots.uv),
      .b        (dots.wu),
      .p        (prods.uvwu)
   );

   pit_wide_mul u_mul_uuwv (
      .clock    (clock),
      .stage_en (stage_en[DOT_STAGES+MUL_STAGES-1:DOT_STAGES]),
      .a        (dots.uu),
      .b        (dots.wv),
      .p        (prods.uuwv)
   );

   pit_decide u_decide (
      .clock    (clock),
      .stage_en (stage_en[NUM_STAGES-1:DOT_STAGES+MUL_STAGES]),
      .prods    (prods),
      .result   (rsp_data)
   );

endmodule

[bench/pit_result_checker.sv]
`timescale 1ns / 1ps

module pit_result_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  pit_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  pit_pkg::rsp_type rsp_data,
   output int               mismatch_count,
   output int               pending_results
);
   import pit_pkg::*;

   typedef logic signed [127:0] exact_type;

   rsp_type expected_results[$];
   int      result_index;

   // exact barycentric test with the division folded into the compares
   function automatic rsp_type predict_inside(input req_type q);
      exact_type ux, uy, uz, vx, vy, vz, wx, wy, wz;
      exact_type uu, uv, vv, wu, wv, den, s_num, t_num;
      rsp_type   r;
      ux = $signed(q.v1_x) - $signed(q.v0_x);
      uy = $signed(q.v1_y) - $signed(q.v0_y);
      uz = $signed(q.v1_z) - $signed(q.v0_z);
      vx = $signed(q.v2_x) - $signed(q.v0_x);
      vy = $signed(q.v2_y) - $signed(q.v0_y);
      vz = $signed(q.v2_z) - $signed(q.v0_z);
      wx = $signed(q.point_x) - $signed(q.v0_x);
      wy = $signed(q.point_y) - $signed(q.v0_y);
      wz = $signed(q.point_z) - $signed(q.v0_z);
      uu = ux * ux + uy * uy + uz * uz;
      uv = ux * vx + uy * vy + uz * vz;
      vv = vx * vx + vy * vy + vz * vz;
      wu = wx * ux + wy * uy + wz * uz;
      wv = wx * vx + wy * vy + wz * vz;
      den   = uv * uv - uu * vv;
      s_num = uv * wv - vv * wu;
      t_num = uv * wu - uu * wv;
      r.degenerate = (den == 0);
      r.inside_res = !r.degenerate && (s_num <= 0) && (s_num >= den) && (t_num <= 0)
                     && (s_num + t_num >= den);
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with no item pending",
                                         result_index));
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.inside_res !== want.inside_res)
                  report_mismatch($sformatf("result %0d inside_res expected %0b got %b",
                                            result_index, want.inside_res,
                                            rsp_data.inside_res));
               if (rsp_data.degenerate !== want.degenerate)
                  report_mismatch($sformatf("result %0d degenerate expected %0b got %b",
                                            result_index, want.degenerate,
                                            rsp_data.degenerate));
            end
            result_index++;
         end
         if (req_valid && !req_stall)
            expected_results.push_back(predict_inside(req_data));
      end
      pending_results <= expected_results.size();
   end

endmodule

[bench/point_in_triangle_test_unit_tb.sv]
`timescale 1ns / 1ps

module point_in_triangle_test_unit_tb;
   import pit_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 400;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int mismatch_count;
   int pending_results;
   int cycle_count;
   int gapless_left = 0;

   point_in_triangle_test_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   pit_result_checker result_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic req_type make_query(
      input int ax, input int ay, input int az,
      input int bx, input int by, input int bz,
      input int cx, input int cy, input int cz,
      input int px, input int py, input int pz);
      req_type q;
      q.v0_x = COORD_WIDTH'(ax);  q.v0_y = COORD_WIDTH'(ay);  q.v0_z = COORD_WIDTH'(az);
      q.v1_x = COORD_WIDTH'(bx);  q.v1_y = COORD_WIDTH'(by);  q.v1_z = COORD_WIDTH'(bz);
      q.v2_x = COORD_WIDTH'(cx);  q.v2_y = COORD_WIDTH'(cy);  q.v2_z = COORD_WIDTH'(cz);
      q.point_x = COORD_WIDTH'(px);
      q.point_y = COORD_WIDTH'(py);
      q.point_z = COORD_WIDTH'(pz);
      return q;
   endfunction

   function automatic req_type random_query();
      req_type q;
      int c[9];
      int p[3];
      int span, n, a0, a1, a2, k, mode;
      mode = $urandom_range(0, 9);
      if (mode < 2) begin
         // any coordinates, mostly outside
         q = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      end else if (mode < 9 && mode != 2) begin
         // point as a weighted mix of the vertices, near or on the triangle
         span = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(1, 2000);
         for (int i = 0; i < 9; i++)
            c[i] = $urandom_range(0, 2 * span) - span;
         n  = $urandom_range(1, 8);
         a1 = $urandom_range(0, n);
         a2 = $urandom_range(0, n - a1);
         a0 = n - a1 - a2;
         for (int i = 0; i < 3; i++)
            p[i] = (a0 * c[i] + a1 * c[3 + i] + a2 * c[6 + i]) / n;
         if (span <= 2000 && $urandom_range(0, 1))
            p[$urandom_range(0, 2)] += $urandom_range(0, 2000) - 1000;
         if (span <= 2000 && $urandom_range(0, 3) == 0)
            p[$urandom_range(0, 2)] += $urandom_range(0, 4) - 2;
         q = make_query(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8],
                        p[0], p[1], p[2]);
      end else begin
         // collinear or coincident vertices
         k = $urandom_range(0, 6) - 3;
         for (int i = 0; i < 3; i++) begin
            c[i]     = $urandom_range(0, 16000) - 8000;
            c[3 + i] = $urandom_range(0, 4000) - 2000;
            c[6 + i] = c[i] + k * c[3 + i];
            c[3 + i] = c[i] + c[3 + i];
            p[i]     = $urandom_range(0, 65535) - 32768;
         end
         q = make_query(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8],
                        p[0], p[1], p[2]);
      end
      return q;
   endfunction

   task automatic send_query(input req_type q);
      int gap, r;
      if (gapless_left > 0) begin
         gapless_left--;
         gap = 0;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 3) begin
            gapless_left = $urandom_range(20, 60);
            gap = 0;
         end else if (r < 55) begin
            gap = 0;
         end else if (r < 85) begin
            gap = $urandom_range(1, 3);
         end else if (r < 97) begin
            gap = $urandom_range(4, 10);
         end else begin
            gap = $urandom_range(20, 40);
         end
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // receiver backpressure
   initial begin
      int r, len;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         r = $urandom_range(0, 99);
         if (r < 40) begin
            rsp_stall <= 1'b0;
            len = $urandom_range(1, 10);
         end else if (r < 55) begin
            rsp_stall <= 1'b0;
            len = $urandom_range(30, 120);
         end else if (r < 92) begin
            rsp_stall <= 1'b1;
            len = $urandom_range(1, 3);
         end else begin
            rsp_stall <= 1'b1;
            len = $urandom_range(10, 40);
         end
         repeat (len) @(posedge clock);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** point_in_triangle_test_unit: FAILED **");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // all-equal vertices at the extremes
      send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_query(make_query(32767, 32767, 32767, 32767, 32767, 32767,
                            32767, 32767, 32767, 32767, 32767, 32767));
      send_query(make_query(-32768, -32768, -32768, -32768, -32768, -32768,
                            -32768, -32768, -32768, -32768, -32768, -32768));
      // largest right triangle, point just past the hypotenuse and far outside
      send_query(make_query(-32768, -32768, 0, 32767, -32768, 0, -32768, 32767, 0,
                            0, 0, 0));
      send_query(make_query(-32768, -32768, 0, 32767, -32768, 0, -32768, 32767, 0,
                            32767, 32767, 0));
      // point on each vertex
      send_query(make_query(0, 0, 0, 4, 0, 0, 0, 4, 0, 0, 0, 0));
      send_query(make_query(0, 0, 0, 4, 0, 0, 0, 4, 0, 4, 0, 0));
      send_query(make_query(0, 0, 0, 4, 0, 0, 0, 4, 0, 0, 4, 0));
      // on the far edge, just past it, past each leg, and on a leg
      send_query(make_query(0, 0, 0, 4, 0, 0, 0, 4, 0, 2, 2, 0));
      send_query(make_query(0, 0, 0, 4, 0, 0, 0, 4, 0, 2, 3, 0));
      send_query(make_query(0, 0, 0, 4, 0, 0, 0, 4, 0, -1, 1, 0));
      send_query(make_query(0, 0, 0, 4, 0, 0, 0, 4, 0, 1, -1, 0));
      send_query(make_query(0, 0, 0, 4, 0, 0, 0, 4, 0, 0, 2, 0));
      // off-plane points, projection inside and outside
      send_query(make_query(0, 0, 0, 4, 0, 0, 0, 4, 0, 1, 1, 32767));
      send_query(make_query(0, 0, 0, 4, 0, 0, 0, 4, 0, 5, 5, -32768));
      // collinear and coincident vertices
      send_query(make_query(0, 0, 0, 1, 1, 1, 2, 2, 2, 1, 1, 1));
      send_query(make_query(-32768, 0, 32767, 5, 6, 7, 5, 6, 7, 5, 6, 7));
      send_query(make_query(-32768, -32768, -32768, 0, 0, 0, 32766, 32766, 32766,
                            0, 0, 0));
      // widest edge vectors, in all axes and in the y-z plane
      send_query(make_query(32767, -32768, 32767, -32768, 32767, -32768,
                            32767, 32767, -32768, 0, 0, 0));
      send_query(make_query(0, -32768, -32768, 0, 32767, -32768, 0, -32768, 32767,
                            -32768, 100, 100));
      send_query(make_query(0, -32768, -32768, 0, 32767, -32768, 0, -32768, 32767,
                            32767, 32767, 32767));
      // alternating bit patterns
      send_query(make_query(21845, -21846, 21845, -21846, 21845, -21846,
                            21845, 21845, -21846, -21846, 21845, 21845));
      send_query(make_query(-21846, 21845, -21846, 21845, -21846, 21845,
                            -21846, -21846, 21845, 21845, -21846, -21846));

      for (int i = 0; i < RANDOM_ITEMS; i++)
         send_query(random_query());
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (NUM_STAGES + 4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** point_in_triangle_test_unit: PASSED **");
      end else begin
         $display("** point_in_triangle_test_unit: FAILED **");
      end
      $finish;
   end

endmodule
